### design/assert_macros.svh
// Assertion shorthands shared by the RTL in this folder.
// Every macro samples on clk_i and stands down while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that cons holds after ante, at the delay given by n.
`define ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("delayed check failed");

`endif

### design/gelu_pkg.sv
// Package for the GELU (tanh form) datapath: fixed-point constants and
// an elaboration-time divider used to build the tanh table. No dependencies.
package gelu_pkg;

  // Width of one tanh table entry, Q16 with room for exactly 1.0
  localparam int unsigned TH_W = 17;

  // 0.79788456 and 0.044715 in Q30
  localparam logic [29:0] C1_Q30 = 30'd856722023;
  localparam logic [25:0] C2_Q30 = 26'd48012366;

  // 1.0 in Q16 and Q30
  localparam logic [TH_W-1:0] TH_ONE  = 17'd65536;
  localparam logic [63:0]     Q30_ONE = 64'd1 << 30;

  // Shift-subtract unsigned divide, evaluated only while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

### design/gelu_tanh_forward.sv
// GELU, tanh approximation, one signed Q3.12 sample per beat, fully pipelined.
// Each beat is registered at the end of every stage, stage 0 through stage 9, and leaves with done_o.
// Throughput: one beat per cycle; busy is always low since the receiver cannot stall.
// Reset: rst_ni clears the stage valid bits asynchronously; data registers are not reset.
// The tanh table is a constant built at elaboration; no clearing pass is needed.
`include "assert_macros.svh"

module gelu_tanh_forward #(
  parameter int unsigned TANH_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] x_value_i,
  input  logic                           last_in_i,
  output logic                           done_o,
  output logic signed [SAMPLE_WIDTH-1:0] gelu_value_o,
  output logic                           last_out_o
);
  import gelu_pkg::*;

  localparam int unsigned W        = SAMPLE_WIDTH;
  localparam int unsigned FRAC     = W - 4;
  localparam int unsigned LATENCY  = 10;
  localparam int unsigned DEPTH_W  = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int unsigned IDX_W    = $clog2(TANH_TABLE_DEPTH);
  localparam int unsigned S_W      = (W - 2) + DEPTH_W;
  localparam int unsigned ROM_BITS = (TANH_TABLE_DEPTH + 1) * TH_W;

  // 4.0 in the sample format, clamp point and table end
  localparam logic [W-1:0]       Q_FOUR  = W'(1) << (W - 2);
  localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(TANH_TABLE_DEPTH);
  localparam logic [W:0]         MAX_POS = (W + 1)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [W:0]         MAX_NEG = (W + 1)'(64'd1 << (W - 1));
  localparam logic [W+TH_W:0]    RND     = (W + TH_W + 1)'(64'd1 << (TH_W - 1));

  // Table step h = 4/D in Q30 and tanh(h) by its odd series
  localparam logic [63:0] H_Q30  = (64'd4 << 30) / TANH_TABLE_DEPTH;
  localparam logic [63:0] H2_Q30 = (H_Q30 * H_Q30) >> 30;
  localparam logic [63:0] H3_Q30 = (H2_Q30 * H_Q30) >> 30;
  localparam logic [63:0] H5_Q30 = (H3_Q30 * H2_Q30) >> 30;
  localparam logic [63:0] H7_Q30 = (H5_Q30 * H2_Q30) >> 30;
  localparam logic [63:0] TH_Q30 = H_Q30 + (64'd2 * H5_Q30) / 64'd15 - H3_Q30 / 64'd3
                                   - (64'd17 * H7_Q30) / 64'd315;

  // Walk tanh((i+1)h) = (t + th) / (1 + t*th) across the table, round to Q16
  function automatic logic [ROM_BITS-1:0] build_rom();
    logic [ROM_BITS-1:0] rom;
    logic [63:0]         t;
    logic [63:0]         e;
    logic [63:0]         num;
    logic [63:0]         den;
    rom = '0;
    t   = '0;
    for (int i = 0; i <= int'(TANH_TABLE_DEPTH); i++) begin
      e = (t + 64'd8192) >> 14;
      rom[i*TH_W +: TH_W] = (e > 64'(TH_ONE)) ? TH_ONE : e[TH_W-1:0];
      num = (t + TH_Q30) << 30;
      den = Q30_ONE + ((t * TH_Q30) >> 30);
      t   = udiv64(num, den);
      if (t > Q30_ONE) begin
        t = Q30_ONE;
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] TANH_ROM = build_rom();

  // Handshake: the pipe never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits, sign and last flag travel alongside the data
  logic [LATENCY-1:0] valid_q;
  logic [LATENCY-1:0] last_q;
  logic [8:0]         neg_q;
  logic [W-1:0]       a_q [8];

  // Stage 0: magnitude and clamp to 4.0
  logic         neg_d;
  logic [W-1:0] x_u;
  logic [W-1:0] a_d;
  logic [W-2:0] ac_d;
  logic [W-2:0] ac0_q, ac1_q, ac2_q;

  assign x_u   = x_value_i;
  assign neg_d = x_u[W-1];
  assign a_d   = neg_d ? (W'(0) - x_u) : x_u;
  assign ac_d  = (a_d > Q_FOUR) ? Q_FOUR[W-2:0] : a_d[W-2:0];

  // Stage 1: x^2
  logic [2*W-3:0] x2_full;
  logic [W:0]     x2_q;
  assign x2_full = ac0_q * ac0_q;

  // Stage 2: x^3
  logic [2*W-1:0] x3_full;
  logic [W+2:0]   x3_q;
  assign x3_full = x2_q * ac1_q;

  // Stage 3: p = x + 0.044715 x^3
  logic [W+28:0] c2_full;
  logic [W-1:0]  p_d, p_q;
  assign c2_full = C2_Q30 * x3_q;
  assign p_d     = {1'b0, ac2_q} + {1'b0, c2_full[30 +: W-1]};

  // Stage 4: u = 0.79788456 p
  logic [W+29:0] c1_full;
  logic [W-1:0]  u_q;
  assign c1_full = C1_Q30 * p_q;

  // Stage 5: scale by table depth, split into index and fraction
  logic [S_W-1:0]   s_full;
  logic [IDX_W-1:0] idx_q;
  logic [W-3:0]     fr5_q, fr6_q;
  logic             sat5_q, sat6_q;
  assign s_full = u_q[W-3:0] * DEPTH_C;

  // Stage 6: table read of the two neighbors
  logic [IDX_W:0]  idx_nx;
  logic [TH_W-1:0] lo_d, hi_d, diff_d;
  logic [TH_W-1:0] lo_q, diff_q;
  assign idx_nx = {1'b0, idx_q} + (IDX_W + 1)'(1);
  assign lo_d   = TANH_ROM[idx_q * TH_W +: TH_W];
  assign hi_d   = TANH_ROM[idx_nx * TH_W +: TH_W];
  assign diff_d = (hi_d < lo_d) ? '0 : (hi_d - lo_d);

  // Stage 7: interpolate, saturate to one past the table
  logic [TH_W+W-3:0] ip_full;
  logic [TH_W-1:0]   th_d, th_q;
  assign ip_full = diff_q * fr6_q;
  assign th_d    = sat6_q ? TH_ONE : (lo_q + ip_full[W-2 +: TH_W]);

  // Stage 8: a * (1 +/- tanh), sign folded into the factor
  logic [TH_W:0]   factor;
  logic [W+TH_W:0] prod_d, prod_q;
  assign factor = neg_q[7] ? ({1'b0, TH_ONE} - {1'b0, th_q})
                           : ({1'b0, TH_ONE} + {1'b0, th_q});
  assign prod_d = a_q[7] * factor;

  // Stage 9: round half up, halve, saturate and apply sign
  logic [W+TH_W:0] rnd;
  logic [W:0]      mag;
  logic [W:0]      mag_sat;
  logic [W-1:0]    gelu_d, gelu_q;
  assign rnd = prod_q + RND;
  assign mag = rnd[TH_W +: W+1];
  always_comb begin
    if (neg_q[8]) begin
      mag_sat = (mag > MAX_NEG) ? MAX_NEG : mag;
      gelu_d  = W'(0) - mag_sat[W-1:0];
    end else begin
      mag_sat = (mag > MAX_POS) ? MAX_POS : mag;
      gelu_d  = mag_sat[W-1:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LATENCY-2:0], accept};
    end
  end

  // Advance the data stages every cycle
  always_ff @(posedge clk_i) begin
    last_q <= {last_q[LATENCY-2:0], last_in_i};
    neg_q  <= {neg_q[7:0], neg_d};
    a_q[0] <= a_d;
    for (int k = 1; k < 8; k++) begin
      a_q[k] <= a_q[k-1];
    end
    ac0_q   <= ac_d;
    x2_q    <= x2_full[FRAC +: W+1];
    ac1_q   <= ac0_q;
    x3_q    <= x3_full[FRAC +: W+3];
    ac2_q   <= ac1_q;
    p_q     <= p_d;
    u_q     <= c1_full[30 +: W];
    idx_q   <= s_full[W-2 +: IDX_W];
    fr5_q   <= s_full[W-3:0];
    sat5_q  <= (u_q >= Q_FOUR);
    lo_q    <= lo_d;
    diff_q  <= diff_d;
    fr6_q   <= fr5_q;
    sat6_q  <= sat5_q;
    th_q    <= th_d;
    prod_q  <= prod_d;
    gelu_q  <= gelu_d;
  end

  assign done_o       = valid_q[LATENCY-1];
  assign last_out_o   = last_q[LATENCY-1];
  assign gelu_value_o = gelu_q;

  // Every accepted beat comes out with done_o, carrying its own flag
  `ASSERT_DELAY(a_done_latency, start && !busy, LATENCY, done_o)
  `ASSERT_IMPL(a_done_source, done_o, $past(start && !busy, LATENCY))
  `ASSERT_IMPL(a_last_match, done_o, last_out_o == $past(last_in_i, LATENCY))
  `ASSERT_IMPL(a_sign_pos, done_o && !$past(x_value_i[W-1], LATENCY), !gelu_value_o[W-1])

endmodule
